@@ src/csd_pkg.sv @@
// csd_pkg: shared types, constants and helpers of the column span depth shader
// used by the divider cells, the divider chain and the top level
`default_nettype none
package csd_pkg;

   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 16;
   localparam int QUO_BITS     = 32;
   localparam int NUM_BITS     = QUO_BITS + FRAC_BITS;
   localparam int DEN_BITS     = 48;
   localparam int REG_IDX_BITS = 3;

   localparam logic [1:0] KIND_FLOOR   = 2'd0;
   localparam logic [1:0] KIND_CEILING = 2'd1;
   localparam logic [1:0] KIND_WALL    = 2'd2;

   localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH   = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_GREY_MODE      = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_NEAR_BIAS      = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_FAR_LIMIT      = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_FLOOR_COLOUR   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_WALL_COLOUR    = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_OUTLINE_COLOUR = 3'd6;

   localparam logic [31:0]        ALPHA_OPAQUE = 32'hFF00_0000;
   localparam logic [7:0]         GREY_FULL    = 8'hFF;
   localparam logic signed [31:0] DEPTH_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DEPTH_MIN    = 32'sh8000_0000;
   localparam logic [31:0]        QUO_NEG_LIM  = 32'h8000_0000;

   // per-pixel context that rides along every stage
   typedef struct packed {
      logic [23:0]        address;
      logic               span;
      logic               zero_div;
      logic               flag;
      logic [31:0]        flat_colour;
      logic signed [31:0] depth;
      logic signed [31:0] range;
      logic signed [31:0] scale;
   } ctx_type;

   typedef struct packed {
      logic                valid;
      logic [DEN_BITS-1:0] rem;
      logic [QUO_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
      logic [QUO_BITS-1:0] quo;
      logic                ovf;
      ctx_type             ctx;
   } div_type;

   function automatic div_type div_load(input logic valid, input logic [NUM_BITS-1:0] num,
                                        input logic [DEN_BITS-1:0] den, input ctx_type ctx);
      div_type d;
      d.valid = valid;
      d.rem   = DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
      d.num   = num[QUO_BITS-1:0];
      d.den   = den;
      d.quo   = '0;
      // quotient does not fit the cells when the top part already reaches the divisor
      d.ovf   = DEN_BITS'(num[NUM_BITS-1:QUO_BITS]) >= den;
      d.ctx   = ctx;
      return d;
   endfunction

   function automatic logic signed [31:0] sat_quo(input logic [QUO_BITS-1:0] quo,
                                                 input logic ovf, input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (ovf || quo > QUO_NEG_LIM) r = DEPTH_MIN;
         else r = 32'(-quo);
      end else begin
         if (ovf || quo[QUO_BITS-1]) r = DEPTH_MAX;
         else r = 32'(quo);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/csd_ifs.sv @@
// csd_req_if / csd_rsp_if: valid-ready channels for pixel requests and shaded results
// no dependencies
`default_nettype none
interface csd_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        column;
   logic [11:0]        row;
   logic [11:0]        span_start;
   logic [12:0]        span_end;
   logic [1:0]         side_kind;
   logic signed [31:0] edge_ref;
   logic signed [31:0] edge_height;
   logic signed [31:0] depth_range;
   logic signed [31:0] depth_scale;
   logic signed [31:0] wall_depth;
   logic signed [13:0] clip_left;
   logic signed [13:0] clip_right;
   modport source (output valid, column, row, span_start, span_end, side_kind, edge_ref,
                   edge_height, depth_range, depth_scale, wall_depth, clip_left, clip_right,
                   input ready);
   modport sink (input valid, column, row, span_start, span_end, side_kind, edge_ref,
                 edge_height, depth_range, depth_scale, wall_depth, clip_left, clip_right,
                 output ready);
endinterface

interface csd_rsp_if;
   logic               valid;
   logic               ready;
   logic [23:0]        pixel_address;
   logic [31:0]        pixel_colour;
   logic signed [31:0] pixel_depth;
   modport source (output valid, pixel_address, pixel_colour, pixel_depth, input ready);
   modport sink (input valid, pixel_address, pixel_colour, pixel_depth, output ready);
endinterface
`default_nettype wire

@@ src/csd_div_cell.sv @@
// csd_div_cell: one restoring division step, one quotient bit, registered
// depends on csd_pkg
`default_nettype none
module csd_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  csd_pkg::div_type cell_in,
   output csd_pkg::div_type cell_out
);
   import csd_pkg::*;

   div_type             stage_ff;
   div_type             stage_in;
   logic [DEN_BITS+1:0] trial;

   always_comb begin
      trial    = {1'b0, cell_in.rem, cell_in.num[QUO_BITS-1]} - {2'b00, cell_in.den};
      stage_in = cell_in;
      if (!trial[DEN_BITS+1]) begin
         stage_in.rem = trial[DEN_BITS-1:0];
      end else begin
         stage_in.rem = {cell_in.rem[DEN_BITS-2:0], cell_in.num[QUO_BITS-1]};
      end
      stage_in.num = {cell_in.num[QUO_BITS-2:0], 1'b0};
      stage_in.quo = {cell_in.quo[QUO_BITS-2:0], ~trial[DEN_BITS+1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;
endmodule
`default_nettype wire

@@ src/csd_div_chain.sv @@
// csd_div_chain: row of division cells, one quotient bit per cell, one beat per cycle while advance is high
// depends on csd_pkg and csd_div_cell
`default_nettype none
module csd_div_chain (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  csd_pkg::div_type chain_in,
   output csd_pkg::div_type chain_out
);
   import csd_pkg::*;

   div_type link [0:QUO_BITS];

   assign link[0] = chain_in;

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      csd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (link[i]),
         .cell_out (link[i+1])
      );
   end

   assign chain_out = link[QUO_BITS];
endmodule
`default_nettype wire

@@ src/column_span_depth_shader.sv @@
// column_span_depth_shader: per-pixel span depth and colour, fully pipelined
// one beat per cycle sustained while the output keeps accepting results;
// three 32-cell divider chains (interpolant, depth, grey level) hold most of its registers
// the whole pipe holds while a result waits unaccepted in the output register
// synchronous active-high reset clears valid bits and loads register defaults
// depends on csd_pkg, csd_ifs and csd_div_chain
`default_nettype none
module column_span_depth_shader (
   input  logic                               clock,
   input  logic                               reset,
   csd_req_if.sink                            req,
   csd_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  logic [csd_pkg::REG_IDX_BITS-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata
);
   import csd_pkg::*;

   logic [12:0]        screen_width_ff;
   logic               grey_mode_ff;
   logic signed [31:0] near_bias_ff;
   logic [30:0]        far_limit_ff;
   logic [31:0]        floor_colour_ff;
   logic [31:0]        wall_colour_ff;
   logic [31:0]        outline_colour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff   <= 13'd640;
         grey_mode_ff      <= 1'b1;
         near_bias_ff      <= 32'sd65536;
         far_limit_ff      <= 31'd6553600;
         floor_colour_ff   <= 32'hFF80_8080;
         wall_colour_ff    <= 32'hFFFF_FFFF;
         outline_colour_ff <= 32'hFF00_0000;
      end else if (csr_we) begin
         case (csr_index)
            REG_SCREEN_WIDTH:   screen_width_ff   <= csr_wdata[12:0];
            REG_GREY_MODE:      grey_mode_ff      <= csr_wdata[0];
            REG_NEAR_BIAS:      near_bias_ff      <= csr_wdata;
            REG_FAR_LIMIT:      far_limit_ff      <= csr_wdata[30:0];
            REG_FLOOR_COLOUR:   floor_colour_ff   <= csr_wdata;
            REG_WALL_COLOUR:    wall_colour_ff    <= csr_wdata;
            REG_OUTLINE_COLOUR: outline_colour_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   logic advance;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // stage 0: address, wall outline, edge difference
   logic [24:0]        addr_full;
   logic signed [33:0] row_fx;
   logic signed [33:0] ref_x;
   logic               wall_edge;
   logic               span_in;
   ctx_type            s0_ctx_in;
   logic signed [33:0] s0_diff_in;

   logic               s0_valid_ff;
   ctx_type            s0_ctx_ff;
   logic signed [33:0] s0_diff_ff;
   logic signed [31:0] s0_height_ff;

   always_comb begin
      addr_full = 25'(req.row) * 25'(screen_width_ff) + 25'(req.column);
      row_fx    = {{(34 - COORD_BITS - FRAC_BITS){1'b0}}, req.row, {FRAC_BITS{1'b0}}};
      ref_x     = 34'(req.edge_ref);
      if (req.side_kind == KIND_CEILING) s0_diff_in = ref_x - row_fx;
      else s0_diff_in = row_fx - ref_x;
      wall_edge = (req.row == req.span_start) || (({1'b0, req.row} + 13'd1) == req.span_end)
               || (($signed({2'b00, req.column}) - 14'sd1) < req.clip_left)
               || (($signed({2'b00, req.column}) + 14'sd1) > req.clip_right);
      span_in   = (req.side_kind == KIND_FLOOR) || (req.side_kind == KIND_CEILING);
      s0_ctx_in.address     = addr_full[23:0];
      s0_ctx_in.span        = span_in;
      s0_ctx_in.zero_div    = (req.edge_height == 32'sd0);
      s0_ctx_in.flag        = 1'b0;
      s0_ctx_in.flat_colour = span_in ? floor_colour_ff
                            : (wall_edge ? outline_colour_ff : wall_colour_ff);
      s0_ctx_in.depth       = req.wall_depth;
      s0_ctx_in.range       = req.depth_range;
      s0_ctx_in.scale       = req.depth_scale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req.valid;
         s0_ctx_ff    <= s0_ctx_in;
         s0_diff_ff   <= s0_diff_in;
         s0_height_ff <= req.edge_height;
      end
   end

   // stage 1: magnitudes into the interpolant divider
   logic [33:0] diff_mag;
   logic [31:0] height_mag;
   ctx_type     s1_ctx;
   div_type     s1_in;
   div_type     s1_ff;
   div_type     c1_out;

   always_comb begin
      diff_mag    = s0_diff_ff[33] ? 34'(-s0_diff_ff) : 34'(s0_diff_ff);
      height_mag  = s0_height_ff[31] ? 32'(-s0_height_ff) : 32'(s0_height_ff);
      s1_ctx      = s0_ctx_ff;
      s1_ctx.flag = s0_diff_ff[33] ^ s0_height_ff[31];
      s1_in = div_load(s0_valid_ff, {diff_mag[31:0], {FRAC_BITS{1'b0}}},
                       DEN_BITS'(height_mag), s1_ctx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   csd_div_chain u_div_t (
      .clock (clock), .reset (reset), .advance (advance),
      .chain_in (s1_ff), .chain_out (c1_out)
   );

   // stages 2..4: saturate t, multiply by range, add near term
   logic               s2_valid_ff;
   ctx_type            s2_ctx_ff;
   logic signed [31:0] t_ff;
   logic               s3_valid_ff;
   ctx_type            s3_ctx_ff;
   logic signed [63:0] prod_ff;
   logic signed [48:0] d_sum;
   logic               s4_valid_ff;
   ctx_type            s4_ctx_ff;
   logic signed [47:0] d_ff;

   assign d_sum = 49'(near_bias_ff) + 49'(prod_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= c1_out.valid;
         s2_ctx_ff   <= c1_out.ctx;
         t_ff        <= sat_quo(c1_out.quo, c1_out.ovf, c1_out.ctx.flag);
         s3_valid_ff <= s2_valid_ff;
         s3_ctx_ff   <= s2_ctx_ff;
         prod_ff     <= 64'(t_ff) * 64'(s2_ctx_ff.range);
         s4_valid_ff <= s3_valid_ff;
         s4_ctx_ff   <= s3_ctx_ff;
         d_ff        <= d_sum[47:0];
      end
   end

   // stage 5: magnitudes into the depth divider
   logic [47:0] d_mag;
   logic [31:0] scale_mag;
   ctx_type     s5_ctx;
   div_type     s5_in;
   div_type     s5_ff;
   div_type     c2_out;

   always_comb begin
      d_mag           = d_ff[47] ? 48'(-d_ff) : 48'(d_ff);
      scale_mag       = s4_ctx_ff.scale[31] ? 32'(-s4_ctx_ff.scale) : 32'(s4_ctx_ff.scale);
      s5_ctx          = s4_ctx_ff;
      s5_ctx.zero_div = s4_ctx_ff.zero_div || (d_ff == 48'sd0);
      s5_ctx.flag     = s4_ctx_ff.scale[31] ^ d_ff[47];
      s5_in = div_load(s4_valid_ff, {scale_mag, {FRAC_BITS{1'b0}}}, d_mag, s5_ctx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s5_ff <= s5_in;
      end
   end

   csd_div_chain u_div_depth (
      .clock (clock), .reset (reset), .advance (advance),
      .chain_in (s5_ff), .chain_out (c2_out)
   );

   // stage 6: final depth
   ctx_type s6_ctx_in;
   logic    s6_valid_ff;
   ctx_type s6_ctx_ff;

   always_comb begin
      s6_ctx_in = c2_out.ctx;
      if (c2_out.ctx.span) begin
         s6_ctx_in.depth = c2_out.ctx.zero_div ? DEPTH_MAX
                         : sat_quo(c2_out.quo, c2_out.ovf, c2_out.ctx.flag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= c2_out.valid;
         s6_ctx_ff   <= s6_ctx_in;
      end
   end

   // stage 7: grey level numerator 255 * (far - depth) into the grey divider
   logic    in_range;
   logic [30:0] gap;
   ctx_type s7_ctx;
   div_type s7_in;
   div_type s7_ff;
   div_type c3_out;

   always_comb begin
      in_range    = (far_limit_ff != 31'd0) && !s6_ctx_ff.depth[31]
                 && (s6_ctx_ff.depth[30:0] <= far_limit_ff);
      gap         = far_limit_ff - s6_ctx_ff.depth[30:0];
      s7_ctx      = s6_ctx_ff;
      s7_ctx.flag = in_range;
      s7_in = div_load(s6_valid_ff, NUM_BITS'(NUM_BITS'(gap) * NUM_BITS'(GREY_FULL)),
                       DEN_BITS'(far_limit_ff), s7_ctx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ff.valid <= 1'b0;
      end else if (advance) begin
         s7_ff <= s7_in;
      end
   end

   csd_div_chain u_div_grey (
      .clock (clock), .reset (reset), .advance (advance),
      .chain_in (s7_ff), .chain_out (c3_out)
   );

   // stage 8: colour select into the output register
   logic [7:0]         grey;
   logic [31:0]        colour_in;
   logic [23:0]        address_ff;
   logic [31:0]        colour_ff;
   logic signed [31:0] depth_ff;

   always_comb begin
      grey = c3_out.quo[7:0];
      if (!grey_mode_ff) colour_in = c3_out.ctx.flat_colour;
      else if (c3_out.ctx.flag) colour_in = ALPHA_OPAQUE | {8'h00, grey, grey, grey};
      else colour_in = 32'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= c3_out.valid;
         address_ff   <= c3_out.ctx.address;
         colour_ff    <= colour_in;
         depth_ff     <= c3_out.ctx.depth;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel_address = address_ff;
   assign rsp.pixel_colour  = colour_ff;
   assign rsp.pixel_depth   = depth_ff;
endmodule
`default_nettype wire
